// ===== rtl/core/spp_pkg.sv =====
// Shared constants and types for the segment pair proximity test.
package spp_pkg;

  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned ThreshBits       = 16;
  localparam int unsigned ThreshSqBits     = 2 * ThreshBits;
  localparam int unsigned NumTests         = 4;

  // Per-stage load enables, first stage to output register.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } spp_adv_t;

endpackage

// ===== rtl/core/spp_front.sv =====
// Front half: coordinate differences, products and sums (stages 1 to 3).
module spp_front #(
  parameter int unsigned CoordBits = spp_pkg::CoordBitsDefault,
  parameter int unsigned SumBits   = 2 * CoordBits + 3
) (
  input  logic                        clk_i,
  input  spp_pkg::spp_adv_t           adv_i,
  input  logic signed [CoordBits-1:0] ax_i,
  input  logic signed [CoordBits-1:0] ay_i,
  input  logic signed [CoordBits-1:0] bx_i,
  input  logic signed [CoordBits-1:0] by_i,
  input  logic signed [CoordBits-1:0] cx_i,
  input  logic signed [CoordBits-1:0] cy_i,
  input  logic signed [CoordBits-1:0] dx_i,
  input  logic signed [CoordBits-1:0] dy_i,
  output logic signed [SumBits-1:0]   det_o,
  output logic signed [SumBits-1:0]   na_o,
  output logic signed [SumBits-1:0]   nb_o,
  output logic signed [SumBits-1:0]   len_o [2],
  output logic signed [SumBits-1:0]   dt_o [4],
  output logic signed [SumBits-1:0]   ww_o [4],
  output logic signed [SumBits-1:0]   qq_o [4],
  output logic signed [SumBits-1:0]   cr_o [4]
);
  import spp_pkg::*;

  localparam int unsigned DiffBits = CoordBits + 1;
  localparam int unsigned ProdBits = 2 * DiffBits;

  logic signed [DiffBits-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic signed [DiffBits-1:0] d1x_q, d1y_q, d2x_q, d2y_q, ex_q, ey_q;
  logic signed [DiffBits-1:0] wx_q [4], wy_q [4], qx_q [4], qy_q [4];

  // Sign-extend the coordinates by one bit so differences are exact.
  assign ax = DiffBits'(ax_i);
  assign ay = DiffBits'(ay_i);
  assign bx = DiffBits'(bx_i);
  assign by = DiffBits'(by_i);
  assign cx = DiffBits'(cx_i);
  assign cy = DiffBits'(cy_i);
  assign dx = DiffBits'(dx_i);
  assign dy = DiffBits'(dy_i);

  // Stage 1: direction vectors and endpoint offsets.
  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      d1x_q <= bx - ax;
      d1y_q <= by - ay;
      d2x_q <= dx - cx;
      d2y_q <= dy - cy;
      ex_q  <= ax - cx;
      ey_q  <= ay - cy;
      // A against segment C-D
      wx_q[0] <= ax - cx;  wy_q[0] <= ay - cy;
      qx_q[0] <= ax - dx;  qy_q[0] <= ay - dy;
      // B against segment C-D
      wx_q[1] <= bx - cx;  wy_q[1] <= by - cy;
      qx_q[1] <= bx - dx;  qy_q[1] <= by - dy;
      // C against segment A-B
      wx_q[2] <= cx - ax;  wy_q[2] <= cy - ay;
      qx_q[2] <= cx - bx;  qy_q[2] <= cy - by;
      // D against segment A-B
      wx_q[3] <= dx - ax;  wy_q[3] <= dy - ay;
      qx_q[3] <= dx - bx;  qy_q[3] <= dy - by;
    end
  end

  logic signed [ProdBits-1:0] det_a_q, det_b_q, na_a_q, na_b_q, nb_a_q, nb_b_q;
  logic signed [ProdBits-1:0] len_a_q [2], len_b_q [2];
  logic signed [ProdBits-1:0] dt_a_q [4], dt_b_q [4], ww_a_q [4], ww_b_q [4];
  logic signed [ProdBits-1:0] qq_a_q [4], qq_b_q [4], cr_a_q [4], cr_b_q [4];

  // Stage 2: every product, one multiplier each.
  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      det_a_q <= d1x_q * d2y_q;
      det_b_q <= d1y_q * d2x_q;
      na_a_q  <= d2x_q * ey_q;
      na_b_q  <= d2y_q * ex_q;
      nb_a_q  <= d1x_q * ey_q;
      nb_b_q  <= d1y_q * ex_q;
      len_a_q[0] <= d2x_q * d2x_q;
      len_b_q[0] <= d2y_q * d2y_q;
      len_a_q[1] <= d1x_q * d1x_q;
      len_b_q[1] <= d1y_q * d1y_q;
      for (int i = 0; i < NumTests; i++) begin
        if (i < 2) begin
          dt_a_q[i] <= wx_q[i] * d2x_q;
          dt_b_q[i] <= wy_q[i] * d2y_q;
          cr_a_q[i] <= wx_q[i] * d2y_q;
          cr_b_q[i] <= wy_q[i] * d2x_q;
        end else begin
          dt_a_q[i] <= wx_q[i] * d1x_q;
          dt_b_q[i] <= wy_q[i] * d1y_q;
          cr_a_q[i] <= wx_q[i] * d1y_q;
          cr_b_q[i] <= wy_q[i] * d1x_q;
        end
        ww_a_q[i] <= wx_q[i] * wx_q[i];
        ww_b_q[i] <= wy_q[i] * wy_q[i];
        qq_a_q[i] <= qx_q[i] * qx_q[i];
        qq_b_q[i] <= qy_q[i] * qy_q[i];
      end
    end
  end

  // Stage 3: sums and differences of the product pairs.
  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      det_o <= SumBits'(det_a_q) - SumBits'(det_b_q);
      na_o  <= SumBits'(na_a_q) - SumBits'(na_b_q);
      nb_o  <= SumBits'(nb_a_q) - SumBits'(nb_b_q);
      for (int j = 0; j < 2; j++) begin
        len_o[j] <= SumBits'(len_a_q[j]) + SumBits'(len_b_q[j]);
      end
      for (int i = 0; i < NumTests; i++) begin
        dt_o[i] <= SumBits'(dt_a_q[i]) + SumBits'(dt_b_q[i]);
        ww_o[i] <= SumBits'(ww_a_q[i]) + SumBits'(ww_b_q[i]);
        qq_o[i] <= SumBits'(qq_a_q[i]) + SumBits'(qq_b_q[i]);
        cr_o[i] <= SumBits'(cr_a_q[i]) - SumBits'(cr_b_q[i]);
      end
    end
  end

endmodule

// ===== rtl/core/spp_eval.sv =====
// Back half: crossing decision, distance compares and wide squares (stages 4 to 6).
module spp_eval #(
  parameter int unsigned CoordBits = spp_pkg::CoordBitsDefault,
  parameter int unsigned SumBits   = 2 * CoordBits + 3
) (
  input  logic                                 clk_i,
  input  spp_pkg::spp_adv_t                    adv_i,
  input  logic [spp_pkg::ThreshSqBits-1:0]     t2_i,
  input  logic signed [SumBits-1:0]            det_i,
  input  logic signed [SumBits-1:0]            na_i,
  input  logic signed [SumBits-1:0]            nb_i,
  input  logic signed [SumBits-1:0]            len_i [2],
  input  logic signed [SumBits-1:0]            dt_i [4],
  input  logic signed [SumBits-1:0]            ww_i [4],
  input  logic signed [SumBits-1:0]            qq_i [4],
  input  logic signed [SumBits-1:0]            cr_i [4],
  output logic                                 conflict_o,
  output logic                                 cross_o
);
  import spp_pkg::*;

  localparam int unsigned MagBits = SumBits - 1;
  localparam int unsigned LoBits  = CoordBits + 1;
  localparam int unsigned HiBits  = MagBits - LoBits;
  localparam int unsigned CmpBits = (SumBits > ThreshSqBits) ? SumBits : ThreshSqBits;
  localparam int unsigned WideBits = 2 * MagBits + ThreshSqBits;

  logic signed [SumBits-1:0] zero;
  logic [CmpBits-1:0]        t2_ext;
  logic                      cross_d;
  logic [NumTests-1:0]       pre_d, need_d;
  logic [SumBits-1:0]        mag [4];
  logic [SumBits-1:0]        lenu [4];

  assign zero   = '0;
  assign t2_ext = CmpBits'(t2_i);

  // Crossing: both numerators lie between zero and the determinant.
  always_comb begin
    cross_d = 1'b0;
    if (det_i > zero) begin
      cross_d = (na_i >= zero) && (na_i <= det_i) && (nb_i >= zero) && (nb_i <= det_i);
    end else if (det_i < zero) begin
      cross_d = (na_i <= zero) && (na_i >= det_i) && (nb_i <= zero) && (nb_i >= det_i);
    end
  end

  // Endpoint cases settle here; interior cases need the wide products.
  always_comb begin
    for (int i = 0; i < NumTests; i++) begin
      lenu[i]   = $unsigned(len_i[i / 2]);
      mag[i]    = cr_i[i][SumBits-1] ? $unsigned(-cr_i[i]) : $unsigned(cr_i[i]);
      pre_d[i]  = 1'b0;
      need_d[i] = 1'b0;
      if (dt_i[i] <= zero) begin
        pre_d[i] = CmpBits'($unsigned(ww_i[i])) <= t2_ext;
      end else if (len_i[i / 2] <= dt_i[i]) begin
        pre_d[i] = CmpBits'($unsigned(qq_i[i])) <= t2_ext;
      end else begin
        need_d[i] = 1'b1;
      end
    end
  end

  logic                  cross4_q;
  logic [NumTests-1:0]   pre4_q, need4_q;
  logic [LoBits-1:0]     crlo_q [4], lnlo_q [4];
  logic [HiBits-1:0]     crhi_q [4], lnhi_q [4];

  // Stage 4: flags and split magnitudes.
  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      cross4_q <= cross_d;
      pre4_q   <= pre_d;
      need4_q  <= need_d;
      for (int i = 0; i < NumTests; i++) begin
        crlo_q[i] <= mag[i][LoBits-1:0];
        crhi_q[i] <= mag[i][MagBits-1:LoBits];
        lnlo_q[i] <= lenu[i][LoBits-1:0];
        lnhi_q[i] <= lenu[i][MagBits-1:LoBits];
      end
    end
  end

  logic                           cross5_q;
  logic [NumTests-1:0]            pre5_q, need5_q;
  logic [2*HiBits-1:0]            hh_q [4];
  logic [HiBits+LoBits-1:0]       hl_q [4];
  logic [2*LoBits-1:0]            ll_q [4];
  logic [ThreshSqBits+HiBits-1:0] thi_q [4];
  logic [ThreshSqBits+LoBits-1:0] tlo_q [4];

  // Stage 5: partial products of cross squared and threshold squared times length.
  always_ff @(posedge clk_i) begin
    if (adv_i.s5) begin
      cross5_q <= cross4_q;
      pre5_q   <= pre4_q;
      need5_q  <= need4_q;
      for (int i = 0; i < NumTests; i++) begin
        hh_q[i]  <= (2*HiBits)'(crhi_q[i]) * (2*HiBits)'(crhi_q[i]);
        hl_q[i]  <= (HiBits+LoBits)'(crhi_q[i]) * (HiBits+LoBits)'(crlo_q[i]);
        ll_q[i]  <= (2*LoBits)'(crlo_q[i]) * (2*LoBits)'(crlo_q[i]);
        thi_q[i] <= (ThreshSqBits+HiBits)'(t2_i) * (ThreshSqBits+HiBits)'(lnhi_q[i]);
        tlo_q[i] <= (ThreshSqBits+LoBits)'(t2_i) * (ThreshSqBits+LoBits)'(lnlo_q[i]);
      end
    end
  end

  logic [WideBits-1:0] sq [4], tl [4];
  logic [NumTests-1:0] near;

  // Recombine the partial products and compare.
  always_comb begin
    for (int i = 0; i < NumTests; i++) begin
      sq[i] = (WideBits'(hh_q[i]) << (2 * LoBits)) + (WideBits'(hl_q[i]) << (LoBits + 1))
            + WideBits'(ll_q[i]);
      tl[i] = (WideBits'(thi_q[i]) << LoBits) + WideBits'(tlo_q[i]);
      near[i] = pre5_q[i] | (need5_q[i] & (sq[i] <= tl[i]));
    end
  end

  // Stage 6: result register.
  always_ff @(posedge clk_i) begin
    if (adv_i.s6) begin
      cross_o    <= cross5_q;
      conflict_o <= cross5_q | (|near);
    end
  end

endmodule

// ===== rtl/core/segment_pair_proximity_test.sv =====
// Top level of the segment pair proximity test: handshake, threshold register, pipeline.
//
//   channel  direction  handshake                     payload
//   cfg      in         cfg_we_i                      cfg_wdata_i (threshold)
//   in       in         in_valid_i / in_stall_o       first_*, second_* coordinates
//   out      out        out_valid_o / out_stall_i     paths_conflict_o, segments_cross_o
//
// Six register stages: differences, products, sums, flags and splits,
// wide partial products, result register. One transfer can enter every
// cycle while the input is not stalled. Each stage holds only while it is
// full and the one after it holds, so bubbles close up under a stalled output.
// Reset clears the valid bits and the threshold.
module segment_pair_proximity_test #(
  parameter int unsigned CoordBits = spp_pkg::CoordBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [spp_pkg::ThreshBits-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [CoordBits-1:0]        first_start_x_i,
  input  logic signed [CoordBits-1:0]        first_start_y_i,
  input  logic signed [CoordBits-1:0]        first_end_x_i,
  input  logic signed [CoordBits-1:0]        first_end_y_i,
  input  logic signed [CoordBits-1:0]        second_start_x_i,
  input  logic signed [CoordBits-1:0]        second_start_y_i,
  input  logic signed [CoordBits-1:0]        second_end_x_i,
  input  logic signed [CoordBits-1:0]        second_end_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               paths_conflict_o,
  output logic                               segments_cross_o
);
  import spp_pkg::*;

  localparam int unsigned SumBits   = 2 * CoordBits + 3;
  localparam int unsigned NumStages = 6;

  logic [ThreshSqBits-1:0] t2_q;
  logic [NumStages-1:0]    v_q;
  logic [NumStages-1:0]    rdy;
  spp_adv_t                adv;

  // Keep the squared threshold; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_q <= '0;
    end else if (cfg_we_i) begin
      t2_q <= ThreshSqBits'(cfg_wdata_i) * ThreshSqBits'(cfg_wdata_i);
    end
  end

  // A stage loads when empty or when the next stage loads.
  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign adv = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4], s6: rdy[5]};

  // Advance valid bits with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NumStages-1];

  logic signed [SumBits-1:0] det, na, nb;
  logic signed [SumBits-1:0] len [2];
  logic signed [SumBits-1:0] dt [4], ww [4], qq [4], cr [4];

  spp_front #(.CoordBits(CoordBits), .SumBits(SumBits)) u_front (
    .clk_i (clk_i),
    .adv_i (adv),
    .ax_i  (first_start_x_i),
    .ay_i  (first_start_y_i),
    .bx_i  (first_end_x_i),
    .by_i  (first_end_y_i),
    .cx_i  (second_start_x_i),
    .cy_i  (second_start_y_i),
    .dx_i  (second_end_x_i),
    .dy_i  (second_end_y_i),
    .det_o (det),
    .na_o  (na),
    .nb_o  (nb),
    .len_o (len),
    .dt_o  (dt),
    .ww_o  (ww),
    .qq_o  (qq),
    .cr_o  (cr)
  );

  spp_eval #(.CoordBits(CoordBits), .SumBits(SumBits)) u_eval (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .t2_i       (t2_q),
    .det_i      (det),
    .na_i       (na),
    .nb_i       (nb),
    .len_i      (len),
    .dt_i       (dt),
    .ww_i       (ww),
    .qq_i       (qq),
    .cr_i       (cr),
    .conflict_o (paths_conflict_o),
    .cross_o    (segments_cross_o)
  );

  // Input holds only when every stage is full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with an empty stage");

  // Input never holds unless the output holds.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output stall");

  // An accepted transfer lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted transfer lost at first stage");

  // A crossing always reports a conflict.
  a_cross_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && segments_cross_o) |-> paths_conflict_o)
    else $error("crossing without conflict");

endmodule

// ===== verif/tb_segment_pair_proximity_test.sv =====
// Self-checking testbench for the segment pair proximity test block.
`timescale 1ns / 100ps

module tb_segment_pair_proximity_test;

  localparam int unsigned CoordBits = spp_pkg::CoordBitsDefault;
  localparam int unsigned LatencyCycles = 6;
  localparam int unsigned RandomPairs = 1100;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
  } seg_pair_t;

  typedef struct {
    logic conflict;
    logic crosses;
  } verdict_t;

  typedef struct {
    seg_pair_t p;
    logic      known;
    verdict_t  v;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [spp_pkg::ThreshBits-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  coord_t first_start_x_i = '0, first_start_y_i = '0, first_end_x_i = '0, first_end_y_i = '0;
  coord_t second_start_x_i = '0, second_start_y_i = '0;
  coord_t second_end_x_i = '0, second_end_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic paths_conflict_o, segments_cross_o;

  logic [spp_pkg::ThreshBits-1:0] threshold_model = '0;
  verdict_t verdict_queue[$];
  int unsigned mismatch_count = 0;
  logic quiet_phase = 1'b0;

  segment_pair_proximity_test #(.CoordBits(CoordBits)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .first_start_x_i, .first_start_y_i, .first_end_x_i, .first_end_y_i,
    .second_start_x_i, .second_start_y_i, .second_end_x_i, .second_end_y_i,
    .out_valid_o, .out_stall_i, .paths_conflict_o, .segments_cross_o
  );

  always #10 clk_i = ~clk_i;

  // ax*by - ay*bx at full width
  function automatic wide_t cross_w(wide_t ax, wide_t ay, wide_t bx, wide_t by);
    return ax * by - ay * bx;
  endfunction

  function automatic logic point_near_segment(wide_t px, wide_t py, wide_t sx, wide_t sy,
                                              wide_t ex, wide_t ey, wide_t t2);
    wide_t vx, vy, wx, wy, dt, len, cr;
    vx = ex - sx; vy = ey - sy;
    wx = px - sx; wy = py - sy;
    dt = wx * vx + wy * vy;
    if (dt <= 0) return (wx * wx + wy * wy) <= t2;
    len = vx * vx + vy * vy;
    if (len <= dt) return ((px - ex) * (px - ex) + (py - ey) * (py - ey)) <= t2;
    cr = cross_w(wx, wy, vx, vy);
    return cr * cr <= t2 * len;
  endfunction

  function automatic verdict_t predict_conflict(seg_pair_t p);
    wide_t ax, ay, bx, by, cx, cy, dx, dy, det, na, nb, t2;
    verdict_t v;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
    det = cross_w(bx - ax, by - ay, dx - cx, dy - cy);
    v.crosses = 1'b0;
    if (det != 0) begin
      na = cross_w(dx - cx, dy - cy, ax - cx, ay - cy);
      nb = cross_w(bx - ax, by - ay, ax - cx, ay - cy);
      if (det < 0) begin
        det = -det; na = -na; nb = -nb;
      end
      v.crosses = (na >= 0) && (na <= det) && (nb >= 0) && (nb <= det);
    end
    t2 = wide_t'(threshold_model) * wide_t'(threshold_model);
    v.conflict = v.crosses ||
      point_near_segment(ax, ay, cx, cy, dx, dy, t2) ||
      point_near_segment(bx, by, cx, cy, dx, dy, t2) ||
      point_near_segment(cx, cy, ax, ay, bx, by, t2) ||
      point_near_segment(dx, dy, ax, ay, bx, by, t2);
    return v;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch %s: got %0b want %0b at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Pick the length of one gap now and then, none in the quiet phase.
  function automatic int unsigned gap_len();
    if (!quiet_phase && $urandom_range(0, 7) == 0) return $urandom_range(1, 17);
    return 0;
  endfunction

  // Write the threshold while nothing is in flight.
  task automatic write_threshold(logic [spp_pkg::ThreshBits-1:0] val);
    in_valid_i <= 1'b0;
    wait (verdict_queue.size() == 0);
    repeat (LatencyCycles + 2) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    threshold_model = val;
  endtask

  task automatic send_pair(seg_pair_t p);
    int unsigned n;
    n = gap_len();
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_start_x_i <= p.ax; first_start_y_i <= p.ay;
    first_end_x_i <= p.bx; first_end_y_i <= p.by;
    second_start_x_i <= p.cx; second_start_y_i <= p.cy;
    second_end_x_i <= p.dx; second_end_y_i <= p.dy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    verdict_queue.push_back(predict_conflict(p));
    @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord(int unsigned span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($signed($urandom_range(0, 2 * span)) - $signed(span));
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int unsigned span;
    case ($urandom_range(0, 3))
      0: span = 0;
      1: span = 40;
      2: span = 2000;
      default: span = 300;
    endcase
    p.ax = rand_coord(span); p.ay = rand_coord(span);
    p.bx = rand_coord(span); p.by = rand_coord(span);
    p.cx = rand_coord(span); p.cy = rand_coord(span);
    p.dx = rand_coord(span); p.dy = rand_coord(span);
    // make some segments parallel, degenerate or share an endpoint
    case ($urandom_range(0, 9))
      0: begin p.dx = p.cx + (p.bx - p.ax); p.dy = p.cy + (p.by - p.ay); end
      1: begin p.bx = p.ax; p.by = p.ay; end
      2: begin p.cx = p.bx; p.cy = p.by; end
      default: ;
    endcase
    return p;
  endfunction

  // Check each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_queue.size() == 0) begin
        report_mismatch("unexpected result", paths_conflict_o, 1'b0);
      end else begin
        want = verdict_queue.pop_front();
        if (paths_conflict_o !== want.conflict)
          report_mismatch("paths_conflict", paths_conflict_o, want.conflict);
        if (segments_cross_o !== want.crosses)
          report_mismatch("segments_cross", segments_cross_o, want.crosses);
      end
    end
  end

  // Stall the output in random bursts.
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = gap_len();
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  localparam coord_t MaxC = coord_t'(16'sh7fff);
  localparam coord_t MinC = coord_t'(16'sh8000);

  initial begin
    stim_row_t rows[$];
    seg_pair_t p;
    verdict_t got;
    logic [spp_pkg::ThreshBits-1:0] thresholds[4];
    int unsigned k;

    // crossing X, touching end, parallel, collinear overlap, degenerate, extremes
    rows.push_back('{'{-10, 0, 10, 0, 0, -10, 0, 10}, 1'b1, '{1'b1, 1'b1}});
    rows.push_back('{'{0, 0, 10, 0, 10, 0, 10, 10}, 1'b1, '{1'b1, 1'b1}});
    rows.push_back('{'{0, 0, 10, 0, 0, 5, 10, 5}, 1'b1, '{1'b0, 1'b0}});
    rows.push_back('{'{0, 0, 10, 0, 5, 0, 20, 0}, 1'b1, '{1'b1, 1'b0}});
    rows.push_back('{'{3, 3, 3, 3, 3, 3, 3, 3}, 1'b1, '{1'b1, 1'b0}});
    rows.push_back('{'{3, 3, 3, 3, 4, 4, 4, 4}, 1'b1, '{1'b0, 1'b0}});
    rows.push_back('{'{MinC, MinC, MaxC, MaxC, MinC, MaxC, MaxC, MinC}, 1'b1, '{1'b1, 1'b1}});
    rows.push_back('{'{MinC, MinC, MaxC, MinC, MinC, MaxC, MaxC, MaxC}, 1'b1, '{1'b0, 1'b0}});
    rows.push_back('{'{0, 0, 10, 0, 20, 1, 30, 1}, 1'b0, '{1'b0, 1'b0}});
    rows.push_back('{'{0, 0, 10, 0, -5, 2, -5, 8}, 1'b0, '{1'b0, 1'b0}});
    rows.push_back('{'{0, 0, 10, 0, 5, 3, 5, 9}, 1'b0, '{1'b0, 1'b0}});
    rows.push_back('{'{0, 0, 0, 0, 7, 0, 7, 0}, 1'b0, '{1'b0, 1'b0}});
    rows.push_back('{'{-1, -1, -1, -1, MaxC, MinC, 0, 0}, 1'b0, '{1'b0, 1'b0}});
    thresholds = '{16'd0, 16'd3, 16'd7, 16'hffff};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // walk the directed table under each threshold setting
    foreach (thresholds[t]) begin
      write_threshold(thresholds[t]);
      foreach (rows[i]) begin
        if (rows[i].known && t == 0) begin
          got = predict_conflict(rows[i].p);
          if (got != rows[i].v)
            report_mismatch("table row", got.conflict, rows[i].v.conflict);
        end
        send_pair(rows[i].p);
      end
    end

    // random pairs with the threshold moved between phases
    for (k = 0; k < RandomPairs; k++) begin
      if (k % 200 == 0) begin
        case ($urandom_range(0, 3))
          0: write_threshold('0);
          1: write_threshold(16'hffff);
          default: write_threshold(16'($urandom_range(0, 600)));
        endcase
      end
      if (k >= RandomPairs - 100) quiet_phase = 1'b1;
      p = rand_pair();
      send_pair(p);
    end
    in_valid_i <= 1'b0;
    wait (verdict_queue.size() == 0);
    repeat (LatencyCycles + 4) @(posedge clk_i);
    if (mismatch_count == 0 && verdict_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/spp_pkg.sv
rtl/core/spp_front.sv
rtl/core/spp_eval.sv
rtl/core/segment_pair_proximity_test.sv
verif/tb_segment_pair_proximity_test.sv
